// File: hdl/rpr_pkg.sv
// Package for the ranked population replacement block.
// Sizes, payload structs and sequencer states; no dependencies.
package rpr_pkg;

    localparam int CAPACITY    = 64;
    localparam int SLOTS       = CAPACITY + 1;
    localparam int KEY_W       = 32;
    localparam int HANDLE_W    = 16;
    localparam int SIZE_W      = 7;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int ADDR_W      = $clog2(SLOTS);
    localparam int PADDR_W     = 3;

    typedef struct packed {
        logic [HANDLE_W-1:0]     genome_id;
        logic signed [KEY_W-1:0] fitness_key;
        logic [SIZE_W-1:0]       target_size;
    } in_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0]       insert_rank;
        logic                    duplicate;
        logic                    evicted_valid;
        logic [HANDLE_W-1:0]     evicted_id;
        logic signed [KEY_W-1:0] evicted_fitness;
        logic                    forced_eviction;
        logic                    last;
    } out_item_t;

    typedef struct packed {
        logic              minimize_score;
        logic [CNT_W-1:0]  elite_lim;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DSCAN_RD, ST_DSCAN_CK, ST_DUP_OUT,
        ST_RINS_RD, ST_RINS_WR, ST_RINS_PUT,
        ST_EL_SEL, ST_EHEAD_RD, ST_EHEAD_CK,
        ST_ESCAN_RD, ST_ESCAN_CK,
        ST_EINS_RD, ST_EINS_WR, ST_EINS_PUT,
        ST_AGE_PUSH,
        ST_EDEL_RD, ST_EDEL_WR,
        ST_EV_CHECK, ST_AGE_RD, ST_AGE_CK,
        ST_RFIND_RD, ST_RFIND_CK,
        ST_RGET_RD, ST_RGET_CK,
        ST_RDEL_RD, ST_RDEL_WR,
        ST_EFIND_RD, ST_EFIND_CK,
        ST_EV_OUT, ST_FIN_OUT
    } state_t;

endpackage

// File: hdl/rpr_ram.sv
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module rpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hdl/rpr_cmp.sv
// Shared key comparator: order under the current sense, and equality.
// Depends on rpr_pkg.
module rpr_cmp (
    input  logic                             minimize_score,
    input  logic signed [rpr_pkg::KEY_W-1:0] a,
    input  logic signed [rpr_pkg::KEY_W-1:0] b,
    output logic                             a_worse,
    output logic                             equal
);
    import rpr_pkg::*;

    always_comb
    begin
        a_worse = minimize_score ? (a > b) : (a < b);
        equal   = (a == b);
    end
endmodule

// File: hdl/rpr_ctrl.sv
// Sequencer with the ranked table, elite list and age queue memories.
// Depends on rpr_pkg, rpr_ram and rpr_cmp.
module rpr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  rpr_pkg::cfg_t       cfg,
    input  logic                in_valid,
    input  rpr_pkg::in_item_t   in_data,
    output logic                in_stall,
    output logic                res_valid,
    output rpr_pkg::out_item_t  res,
    input  logic                res_take
);
    import rpr_pkg::*;

    state_t state_reg, state_next;

    logic [HANDLE_W-1:0] id_reg, eh_reg;
    logic [KEY_W-1:0]    key_reg, ehead_reg, old_reg, ek_reg;
    logic [CNT_W-1:0]    tgt_reg, n_reg, ec_reg, ac_reg, i_reg;
    logic [CNT_W-1:0]    pos_reg, epos_reg, idx_reg;
    logic [ADDR_W-1:0]   head_reg;
    logic                posf_reg, disp_reg, forced_reg, ev_reg;

    // memory ports
    logic                         r_we, e_we, a_we;
    logic [ADDR_W-1:0]            r_waddr, r_raddr, e_waddr, e_raddr, a_waddr;
    logic [KEY_W+HANDLE_W-1:0]    r_wdata, r_rdata;
    logic [KEY_W-1:0]             e_wdata, e_rdata, a_wdata, a_rdata;
    logic [KEY_W-1:0]             r_rkey;
    logic [HANDLE_W-1:0]          r_rhandle;

    logic [KEY_W-1:0] cmp_a, cmp_b;
    logic             worse, equal;
    logic [CNT_W:0]   tail_sum;
    logic [ADDR_W-1:0] tail, head_inc;
    logic [CNT_W-1:0] tgt_in;

    assign r_rkey    = r_rdata[KEY_W+HANDLE_W-1:HANDLE_W];
    assign r_rhandle = r_rdata[HANDLE_W-1:0];

    rpr_ram #(.WIDTH(KEY_W + HANDLE_W), .DEPTH(SLOTS)) u_rank (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    rpr_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_elite (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    rpr_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_age (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(head_reg), .rdata(a_rdata)
    );

    rpr_cmp u_cmp (
        .minimize_score(cfg.minimize_score),
        .a(cmp_a), .b(cmp_b), .a_worse(worse), .equal(equal)
    );

    // age queue is circular over SLOTS entries
    always_comb
    begin
        tail_sum = {1'b0, CNT_W'(head_reg)} + {1'b0, ac_reg};
        if (tail_sum >= (CNT_W+1)'(SLOTS))
        begin
            tail = ADDR_W'(tail_sum - (CNT_W+1)'(SLOTS));
        end
        else
        begin
            tail = ADDR_W'(tail_sum);
        end
        if (head_reg == ADDR_W'(SLOTS - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (in_data.target_size == '0)
        begin
            tgt_in = n_reg;
        end
        else if (in_data.target_size > SIZE_W'(CAPACITY))
        begin
            tgt_in = CNT_W'(CAPACITY);
        end
        else
        begin
            tgt_in = CNT_W'(in_data.target_size);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_DSCAN_RD;
            ST_DSCAN_RD: state_next = (i_reg >= n_reg) ? ST_RINS_RD : ST_DSCAN_CK;
            ST_DSCAN_CK: state_next = equal ? ST_DUP_OUT : ST_DSCAN_RD;
            ST_DUP_OUT:  if (res_take) state_next = ST_IDLE;
            ST_RINS_RD:  state_next = (i_reg > pos_reg) ? ST_RINS_WR : ST_RINS_PUT;
            ST_RINS_WR:  state_next = ST_RINS_RD;
            ST_RINS_PUT: state_next = ST_EL_SEL;
            ST_EL_SEL:
            begin
                if (cfg.elite_lim == '0)
                begin
                    state_next = ST_AGE_PUSH;
                end
                else if (ec_reg < cfg.elite_lim)
                begin
                    state_next = ST_ESCAN_RD;
                end
                else
                begin
                    state_next = ST_EHEAD_RD;
                end
            end
            ST_EHEAD_RD: state_next = ST_EHEAD_CK;
            ST_EHEAD_CK: state_next = worse ? ST_ESCAN_RD : ST_AGE_PUSH;
            ST_ESCAN_RD: state_next = (i_reg >= ec_reg) ? ST_EINS_RD : ST_ESCAN_CK;
            ST_ESCAN_CK: state_next = worse ? ST_ESCAN_RD : ST_EINS_RD;
            ST_EINS_RD:  state_next = (i_reg > epos_reg) ? ST_EINS_WR : ST_EINS_PUT;
            ST_EINS_WR:  state_next = ST_EINS_RD;
            ST_EINS_PUT: state_next = disp_reg ? ST_AGE_PUSH : ST_EV_CHECK;
            ST_AGE_PUSH: state_next = disp_reg ? ST_EDEL_RD : ST_EV_CHECK;
            ST_EDEL_RD:
            begin
                if ((i_reg + 1'b1) < ec_reg)
                begin
                    state_next = ST_EDEL_WR;
                end
                else
                begin
                    state_next = ev_reg ? ST_EV_OUT : ST_EV_CHECK;
                end
            end
            ST_EDEL_WR:  state_next = ST_EDEL_RD;
            ST_EV_CHECK:
            begin
                if (n_reg > tgt_reg)
                begin
                    state_next = (ac_reg != '0) ? ST_AGE_RD : ST_RGET_RD;
                end
                else
                begin
                    state_next = ST_FIN_OUT;
                end
            end
            ST_AGE_RD:   state_next = ST_AGE_CK;
            ST_AGE_CK:   state_next = ST_RFIND_RD;
            ST_RFIND_RD: state_next = (i_reg >= n_reg) ? ST_RGET_RD : ST_RFIND_CK;
            ST_RFIND_CK: state_next = equal ? ST_RGET_RD : ST_RFIND_RD;
            ST_RGET_RD:  state_next = ST_RGET_CK;
            ST_RGET_CK:  state_next = ST_RDEL_RD;
            ST_RDEL_RD:  state_next = ((i_reg + 1'b1) < n_reg) ? ST_RDEL_WR : ST_EFIND_RD;
            ST_RDEL_WR:  state_next = ST_RDEL_RD;
            ST_EFIND_RD: state_next = (i_reg >= ec_reg) ? ST_EV_OUT : ST_EFIND_CK;
            ST_EFIND_CK: state_next = equal ? ST_EDEL_RD : ST_EFIND_RD;
            ST_EV_OUT:
            begin
                if (res_take)
                begin
                    state_next = (n_reg <= tgt_reg) ? ST_IDLE : ST_EV_CHECK;
                end
            end
            ST_FIN_OUT:  if (res_take) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // memory ports, comparator operands and result
    always_comb
    begin
        r_we    = 1'b0;
        r_waddr = i_reg[ADDR_W-1:0];
        r_wdata = r_rdata;
        r_raddr = i_reg[ADDR_W-1:0];
        e_we    = 1'b0;
        e_waddr = i_reg[ADDR_W-1:0];
        e_wdata = e_rdata;
        e_raddr = i_reg[ADDR_W-1:0];
        a_we    = 1'b0;
        a_waddr = tail;
        a_wdata = disp_reg ? ehead_reg : key_reg;
        cmp_a   = r_rkey;
        cmp_b   = key_reg;
        in_stall  = (state_reg != ST_IDLE);
        res_valid = 1'b0;
        res = '{insert_rank: SIZE_W'(pos_reg), duplicate: 1'b0, evicted_valid: 1'b0,
                evicted_id: '0, evicted_fitness: '0, forced_eviction: 1'b0,
                last: 1'b1};
        case (state_reg)
            ST_RINS_RD:  r_raddr = ADDR_W'(i_reg - 1'b1);
            ST_RINS_WR:  r_we = 1'b1;
            ST_RINS_PUT:
            begin
                r_we    = 1'b1;
                r_waddr = pos_reg[ADDR_W-1:0];
                r_wdata = {key_reg, id_reg};
            end
            ST_EHEAD_RD: e_raddr = '0;
            ST_EHEAD_CK: cmp_a = e_rdata;
            ST_ESCAN_CK: cmp_a = e_rdata;
            ST_EINS_RD:  e_raddr = ADDR_W'(i_reg - 1'b1);
            ST_EINS_WR:  e_we = 1'b1;
            ST_EINS_PUT:
            begin
                e_we    = 1'b1;
                e_waddr = epos_reg[ADDR_W-1:0];
                e_wdata = key_reg;
            end
            ST_AGE_PUSH: a_we = 1'b1;
            ST_EDEL_RD:  e_raddr = ADDR_W'(i_reg + 1'b1);
            ST_EDEL_WR:  e_we = 1'b1;
            ST_RFIND_CK: cmp_b = old_reg;
            ST_RGET_RD:  r_raddr = idx_reg[ADDR_W-1:0];
            ST_RDEL_RD:  r_raddr = ADDR_W'(i_reg + 1'b1);
            ST_RDEL_WR:  r_we = 1'b1;
            ST_EFIND_CK:
            begin
                cmp_a = e_rdata;
                cmp_b = ek_reg;
            end
            ST_DUP_OUT:
            begin
                res_valid     = 1'b1;
                res.duplicate = 1'b1;
            end
            ST_EV_OUT:
            begin
                res_valid           = 1'b1;
                res.evicted_valid   = 1'b1;
                res.evicted_id      = eh_reg;
                res.evicted_fitness = ek_reg;
                res.forced_eviction = forced_reg;
                res.last            = (n_reg <= tgt_reg);
            end
            ST_FIN_OUT:  res_valid = 1'b1;
            default:     ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            ec_reg    <= '0;
            ac_reg    <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_RINS_PUT: n_reg <= n_reg + 1'b1;
                ST_EINS_PUT: ec_reg <= ec_reg + 1'b1;
                ST_AGE_PUSH: ac_reg <= ac_reg + 1'b1;
                ST_EDEL_RD:
                begin
                    if ((i_reg + 1'b1) >= ec_reg)
                    begin
                        ec_reg <= ec_reg - 1'b1;
                    end
                end
                ST_AGE_CK:
                begin
                    ac_reg   <= ac_reg - 1'b1;
                    head_reg <= head_inc;
                end
                ST_RDEL_RD:
                begin
                    if ((i_reg + 1'b1) >= n_reg)
                    begin
                        n_reg <= n_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                id_reg   <= in_data.genome_id;
                key_reg  <= in_data.fitness_key;
                tgt_reg  <= tgt_in;
                i_reg    <= '0;
                pos_reg  <= n_reg;
                posf_reg <= 1'b0;
                disp_reg <= 1'b0;
                ev_reg   <= 1'b0;
            end
            ST_DSCAN_RD: if (i_reg >= n_reg) i_reg <= n_reg;
            ST_DSCAN_CK:
            begin
                if (equal)
                begin
                    pos_reg <= i_reg;
                end
                else
                begin
                    if (!posf_reg && !worse)
                    begin
                        pos_reg  <= i_reg;
                        posf_reg <= 1'b1;
                    end
                    i_reg <= i_reg + 1'b1;
                end
            end
            ST_RINS_WR:  i_reg <= i_reg - 1'b1;
            ST_EL_SEL:
            begin
                i_reg    <= '0;
                epos_reg <= ec_reg;
            end
            ST_EHEAD_CK:
            begin
                if (worse)
                begin
                    ehead_reg <= e_rdata;
                    disp_reg  <= 1'b1;
                end
            end
            ST_ESCAN_RD: if (i_reg >= ec_reg) i_reg <= ec_reg;
            ST_ESCAN_CK:
            begin
                if (worse)
                begin
                    i_reg <= i_reg + 1'b1;
                end
                else
                begin
                    epos_reg <= i_reg;
                    i_reg    <= ec_reg;
                end
            end
            ST_EINS_WR:  i_reg <= i_reg - 1'b1;
            ST_AGE_PUSH:
            begin
                // displaced head leaves the elite list from index zero
                i_reg    <= '0;
                disp_reg <= 1'b0;
            end
            ST_EDEL_WR:  i_reg <= i_reg + 1'b1;
            ST_EV_CHECK:
            begin
                ev_reg     <= 1'b1;
                i_reg      <= '0;
                idx_reg    <= '0;
                forced_reg <= (ac_reg == '0);
            end
            ST_AGE_CK:   old_reg <= a_rdata;
            ST_RFIND_RD: if (i_reg >= n_reg) forced_reg <= 1'b1;
            ST_RFIND_CK:
            begin
                if (equal)
                begin
                    idx_reg <= i_reg;
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            ST_RGET_CK:
            begin
                ek_reg <= r_rkey;
                eh_reg <= r_rhandle;
                i_reg  <= idx_reg;
            end
            ST_RDEL_RD:  if ((i_reg + 1'b1) >= n_reg) i_reg <= '0;
            ST_RDEL_WR:  i_reg <= i_reg + 1'b1;
            ST_EFIND_CK: if (!equal) i_reg <= i_reg + 1'b1;
            default: ;
        endcase
    end
endmodule

// File: hdl/ranked_population_replacement_top.sv
// Top level of the ranked population replacement block: register port and result register.
// Depends on rpr_pkg and rpr_ctrl.
//
// Usage: an insert (genome_id, fitness_key, target_size) is a transfer on the in channel;
// results leave as transfers on the out channel, one per eviction or a single one when
// nothing is evicted, the final one marked by last. A duplicate key gives one result and
// changes nothing. in_stall stays high from acceptance until the final result has been
// loaded into the output register, so one insert is worked on at a time.
// Every pass over the ranked table, elite list or age queue walks one entry at a time
// through a single registered memory read port and one shared comparator.
// Reset clears the member, elite and age counts and both registers; the memories need
// no clearing. When the receiver stalls, the output register holds its transfer and the
// sequencer waits with its next result.
// Registers: minimize_score at byte address 0, elite_limit at 4 (saturated at 64).
module ranked_population_replacement_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rpr_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    input  rpr_pkg::in_item_t                in_data,
    output logic                             in_stall,
    output logic                             out_valid,
    output rpr_pkg::out_item_t               out_data,
    input  logic                             out_stall
);
    import rpr_pkg::*;

    logic              minimize_reg;
    logic [SIZE_W-1:0] elite_limit_reg;
    cfg_t              cfg;
    logic              res_valid, res_take;
    out_item_t         res;
    logic              out_valid_reg;
    out_item_t         out_reg;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {(32-SIZE_W)'(0), elite_limit_reg} : {31'b0, minimize_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minimize_reg    <= 1'b0;
            elite_limit_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
            begin
                elite_limit_reg <= pwdata[SIZE_W-1:0];
            end
            else
            begin
                minimize_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        cfg.minimize_score = minimize_reg;
        if (elite_limit_reg > SIZE_W'(CAPACITY))
        begin
            cfg.elite_lim = CNT_W'(CAPACITY);
        end
        else
        begin
            cfg.elite_lim = CNT_W'(elite_limit_reg);
        end
    end

    rpr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
        .res_valid(res_valid), .res(res), .res_take(res_take)
    );

    // load when empty or when the held transfer leaves this cycle
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

// File: test/tb.sv
// Self-checking testbench for ranked_population_replacement_top.
// Depends on rpr_pkg and the block; inserts go in over the in channel,
// register writes over the APB port, and results are checked by a local model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpr_pkg::*;

    localparam int REG_MINIMIZE = 0;
    localparam int REG_ELITE    = 1;
    localparam int POP_MAX      = 64;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef struct {
        bit               set_cfg;
        bit               minimize;
        int               limit;
        logic [15:0]      id;
        key_t             key;
        logic [6:0]       target;
        bit               has_exp;
        logic [6:0]       exp_rank;
        bit               exp_dup;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    in_item_t           in_data;
    logic               in_stall;
    logic               out_valid;
    out_item_t          out_data;
    logic               out_stall;

    // population model
    key_t        pop_key[$];
    logic [15:0] pop_id[$];
    key_t        elite_keys[$];
    key_t        age_keys[$];
    bit          order_min;
    int          elite_cap;

    out_item_t   pending_results[$];
    int          batch_first;
    int          errors;
    bit          long_hold;

    ranked_population_replacement_top DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
        .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("FAIL ranked_population_replacement_top");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit is_worse(input key_t a, input key_t b);
        return order_min ? (a > b) : (a < b);
    endfunction

    function automatic int first_not_worse(ref key_t list[$], input key_t k);
        int i;
        i = 0;
        while (i < list.size() && is_worse(list[i], k))
            i++;
        return i;
    endfunction

    function automatic int find_key(ref key_t list[$], input key_t k);
        int i;
        i = 0;
        while (i < list.size() && list[i] != k)
            i++;
        return i;
    endfunction

    // work out the results of one accepted insert and advance the model
    function automatic void predict_insert(input in_item_t it);
        out_item_t r;
        out_item_t batch[$];
        int        target;
        int        pos;
        int        idx;
        int        lim;
        key_t      old;
        bit        forced;

        batch_first = pending_results.size();
        target = it.target_size;
        if (target == 0)
            target = pop_key.size();
        if (target > POP_MAX)
            target = POP_MAX;
        r = '0;
        idx = find_key(pop_key, it.fitness_key);
        if (idx < pop_key.size())
        begin
            r.insert_rank = SIZE_W'(idx);
            r.duplicate   = 1'b1;
            r.last        = 1'b1;
            pending_results.insert(pending_results.size(), r);
            return;
        end
        pos = first_not_worse(pop_key, it.fitness_key);
        pop_key.insert(pos, it.fitness_key);
        pop_id.insert(pos, it.genome_id);

        lim = (elite_cap > POP_MAX) ? POP_MAX : elite_cap;
        if (lim == 0)
            age_keys.insert(age_keys.size(), it.fitness_key);
        else if (elite_keys.size() < lim)
            elite_keys.insert(first_not_worse(elite_keys, it.fitness_key), it.fitness_key);
        else if (elite_keys.size() > 0 && is_worse(elite_keys[0], it.fitness_key))
        begin
            // displace the weakest elite entry into the age queue
            elite_keys.insert(first_not_worse(elite_keys, it.fitness_key), it.fitness_key);
            age_keys.insert(age_keys.size(), elite_keys[0]);
            elite_keys.delete(0);
        end
        else
            age_keys.insert(age_keys.size(), it.fitness_key);

        while (pop_key.size() > target)
        begin
            forced = 1'b0;
            idx = pop_key.size();
            if (age_keys.size() > 0)
            begin
                old = age_keys[0];
                age_keys.delete(0);
                idx = find_key(pop_key, old);
            end
            if (idx >= pop_key.size())
            begin
                idx = 0;
                forced = 1'b1;
            end
            r = '0;
            r.insert_rank     = SIZE_W'(pos);
            r.evicted_valid   = 1'b1;
            r.evicted_id      = pop_id[idx];
            r.evicted_fitness = pop_key[idx];
            r.forced_eviction = forced;
            old = pop_key[idx];
            pop_key.delete(idx);
            pop_id.delete(idx);
            idx = find_key(elite_keys, old);
            if (idx < elite_keys.size())
                elite_keys.delete(idx);
            idx = find_key(age_keys, old);
            if (idx < age_keys.size())
                age_keys.delete(idx);
            batch.insert(batch.size(), r);
        end
        if (batch.size() == 0)
        begin
            r = '0;
            r.insert_rank = SIZE_W'(pos);
            batch.insert(batch.size(), r);
        end
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            pending_results.insert(pending_results.size(), batch[i]);
    endfunction

    task automatic reg_write(input int index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(index * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_MINIMIZE)
            order_min = value[0];
        else
            elite_cap = value[6:0];
        @(posedge clk);
    endtask

    task automatic wait_drained;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic configure(input bit minimize, input int limit);
        wait_drained();
        reg_write(REG_MINIMIZE, {31'd0, minimize});
        reg_write(REG_ELITE, limit);
    endtask

    // offer one insert; valid stays up when the next gap is zero
    task automatic send_insert(input in_item_t it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        predict_insert(it);
    endtask

    function automatic in_item_t random_insert(input bit filling);
        in_item_t it;
        int pick;
        it.genome_id = HANDLE_W'($urandom);
        it.fitness_key = ($urandom_range(0, 1) == 0) ? key_t'($urandom_range(0, 40)) - 20
                                                      : key_t'($urandom);
        pick = $urandom_range(0, 9);
        if (filling)
            it.target_size = SIZE_W'(POP_MAX);
        else if (pick < 6)
            it.target_size = SIZE_W'($urandom_range(0, 10));
        else if (pick < 9)
            it.target_size = '0;
        else
            it.target_size = SIZE_W'($urandom_range(0, 127));
        return it;
    endfunction

    // result side: random stall, a long hold when asked
    initial
    begin
        int        hold;
        out_item_t e;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            if (long_hold)
            begin
                hold = 400;
                long_hold = 1'b0;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_results.size() == 0)
                report("result transfer with nothing expected");
            else
            begin
                e = pending_results[0];
                pending_results.delete(0);
                if (out_data.insert_rank !== e.insert_rank)
                    report($sformatf("insert_rank %0d, expected %0d",
                                     out_data.insert_rank, e.insert_rank));
                if (out_data.duplicate !== e.duplicate)
                    report($sformatf("duplicate %0b, expected %0b",
                                     out_data.duplicate, e.duplicate));
                if (out_data.evicted_valid !== e.evicted_valid)
                    report($sformatf("evicted_valid %0b, expected %0b",
                                     out_data.evicted_valid, e.evicted_valid));
                if (out_data.evicted_id !== e.evicted_id)
                    report($sformatf("evicted_id %h, expected %h",
                                     out_data.evicted_id, e.evicted_id));
                if (out_data.evicted_fitness !== e.evicted_fitness)
                    report($sformatf("evicted_fitness %h, expected %h",
                                     out_data.evicted_fitness, e.evicted_fitness));
                if (out_data.forced_eviction !== e.forced_eviction)
                    report($sformatf("forced_eviction %0b, expected %0b",
                                     out_data.forced_eviction, e.forced_eviction));
                if (out_data.last !== e.last)
                    report($sformatf("last %0b, expected %0b", out_data.last, e.last));
            end
        end
    end

    initial
    begin
        row_t     rows[$];
        in_item_t it;
        int       fill_cfg[6][2];

        errors    = 0;
        long_hold = 1'b0;
        order_min = 1'b0;
        elite_cap = 0;
        rst_n     = 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        in_data  <= '0;

        //     cfg  min lim  id        key           tgt  typed rank dup
        rows = '{
            '{0, 0, 0,   16'h0000, 32'sh0,         0,   1, 0, 0},  // zero target on empty table
            '{0, 0, 0,   16'hFFFF, 32'sh7FFFFFFF,  64,  1, 0, 0},
            '{0, 0, 0,   16'h0001, 32'sh80000000,  64,  1, 0, 0},
            '{0, 0, 0,   16'h0002, 32'sh7FFFFFFF,  64,  1, 1, 1},  // duplicate
            '{0, 0, 0,   16'h0003, 32'sh0,         127, 1, 1, 0},  // oversize target
            '{0, 0, 0,   16'h0004, 32'sh64,        2,   0, 0, 0},
            '{1, 1, 2,   16'h0005, 32'sh10,        0,   0, 0, 0},  // order flipped, entries held
            '{0, 1, 2,   16'h0006, -32'sh10,       5,   0, 0, 0},
            '{0, 1, 2,   16'h0007, -32'sh20,       5,   0, 0, 0},
            '{0, 1, 2,   16'h0008, 32'sh5,         5,   0, 0, 0},
            '{0, 1, 2,   16'h0009, 32'sh6,         3,   0, 0, 0},
            '{1, 0, 127, 16'h000A, 32'sh1000,      8,   0, 0, 0},  // elite limit saturates
            '{0, 0, 127, 16'h000B, 32'sh2000,      8,   0, 0, 0},
            '{0, 0, 127, 16'h000C, 32'sh3000,      8,   0, 0, 0},
            '{0, 0, 127, 16'h000D, 32'sh4000,      2,   0, 0, 0},  // forced evictions
            '{1, 0, 1,   16'h000E, 32'sh5000,      4,   0, 0, 0},  // limit below elite count
            '{0, 0, 1,   16'h000F, 32'sh6000,      4,   0, 0, 0},
            '{0, 0, 1,   16'hAAAA, 32'sh55555555,  4,   0, 0, 0},
            '{0, 0, 1,   16'h5555, -32'sh55555556, 1,   0, 0, 0},
            '{1, 0, 64,  16'h1234, 32'sh1,         0,   0, 0, 0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].set_cfg)
            begin
                in_valid <= 1'b0;
                configure(rows[i].minimize, rows[i].limit);
            end
            it.genome_id   = rows[i].id;
            it.fitness_key = rows[i].key;
            it.target_size = rows[i].target;
            send_insert(it);
            if (rows[i].has_exp)
            begin
                pending_results[batch_first].insert_rank = rows[i].exp_rank;
                pending_results[batch_first].duplicate   = rows[i].exp_dup;
            end
        end

        fill_cfg = '{'{0, 0}, '{1, 3}, '{0, 64}, '{1, 100}, '{0, 2}, '{1, 0}};
        for (int ph = 0; ph < 6; ph++)
        begin
            in_valid <= 1'b0;
            configure(fill_cfg[ph][0], fill_cfg[ph][1]);
            if (ph == 2)
            begin
                // fill to capacity under a long receiver hold, then shrink hard
                long_hold = 1'b1;
                for (int n = 0; n < 70; n++)
                    send_insert(random_insert(1'b1));
                it = random_insert(1'b0);
                it.target_size = 1;
                send_insert(it);
            end
            else
                for (int n = 0; n < 18; n++)
                    send_insert(random_insert(1'b0));
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("PASS ranked_population_replacement_top");
        else
            $display("FAIL ranked_population_replacement_top");
        $finish;
    end

endmodule
